/* rtl/assert_macros.svh */
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is held.
`define STIS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, skipped while reset is held.
`define STIS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define STIS_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("reset check failed");

`endif

/* rtl/stis_pkg.sv */
// Types and constants of the sorted table block.
package stis_pkg;

    localparam int VAL_W   = 32;
    localparam int CNT_OUT = 5;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    typedef struct packed {
        logic                    command;
        logic signed [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic               found;
        logic               refused;
        logic [CNT_OUT-1:0] entry_count;
    } t_out;

    typedef struct packed {
        t_op                     op;
        logic signed [VAL_W-1:0] value;
    } t_job;

endpackage

/* rtl/stis_front.sv */
// Front end: accepts words, decodes the command and queues jobs for the back end.
module stis_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  stis_pkg::t_in   i_data,
    output logic            o_job_valid,
    input  logic            i_job_pop,
    output stis_pkg::t_job  o_job
);

    stis_pkg::t_job r_q [stis_pkg::QDEPTH];
    logic [stis_pkg::QPTR_W-1:0] r_wptr, n_wptr;
    logic [stis_pkg::QPTR_W-1:0] r_rptr, n_rptr;
    logic [stis_pkg::QPTR_W:0]   r_fill, n_fill;
    logic push, pop;
    stis_pkg::t_job job_in;

    assign o_stall     = (r_fill == (stis_pkg::QPTR_W+1)'(stis_pkg::QDEPTH));
    assign o_job_valid = (r_fill != '0);
    assign o_job       = r_q[r_rptr];
    assign push        = i_valid && !o_stall;
    assign pop         = i_job_pop && o_job_valid;

    always_comb begin
        job_in.op    = i_data.command ? stis_pkg::OP_SEARCH : stis_pkg::OP_INSERT;
        job_in.value = i_data.value;
        n_wptr = push ? r_wptr + 1'b1 : r_wptr;
        n_rptr = pop  ? r_rptr + 1'b1 : r_rptr;
        n_fill = r_fill + (stis_pkg::QPTR_W+1)'(push) - (stis_pkg::QPTR_W+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= job_in;
        end
    end

endmodule

/* rtl/stis_back.sv */
// Back end: compare-and-shift cell chain holding the sorted entries, plus output register.
module stis_back #(
    parameter int DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    output logic            o_job_pop,
    input  stis_pkg::t_job  i_job,
    output logic            o_valid,
    input  logic            i_stall,
    output stis_pkg::t_out  o_data
);

    localparam int CW = $clog2(DEPTH + 1);

    logic signed [stis_pkg::VAL_W-1:0] r_cell [DEPTH];
    logic signed [stis_pkg::VAL_W-1:0] n_cell [DEPTH];
    logic [CW-1:0] r_count, n_count;
    logic [DEPTH-1:0] cell_le, cell_eq;
    logic take, full, do_ins, hit;
    logic [CW+stis_pkg::CNT_OUT-1:0] cnt_ext;
    logic r_out_valid;
    stis_pkg::t_out r_out, n_out;

    assign take      = i_job_valid && (!r_out_valid || !i_stall);
    assign o_job_pop = take;
    assign full      = (r_count == CW'(DEPTH));
    assign do_ins    = take && (i_job.op == stis_pkg::OP_INSERT) && !full;

    // each cell compares its own entry against the incoming value
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            cell_le[k] = (CW'(k) < r_count) && (r_cell[k] <= i_job.value);
            cell_eq[k] = (CW'(k) < r_count) && (r_cell[k] == i_job.value);
        end
        hit = |cell_eq;
    end

    // keep if at or below the value, load the value at the boundary, else shift up
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            if (cell_le[k]) begin
                n_cell[k] = r_cell[k];
            end else if (k == 0) begin
                n_cell[k] = i_job.value;
            end else if (cell_le[k-1]) begin
                n_cell[k] = i_job.value;
            end else begin
                n_cell[k] = r_cell[k-1];
            end
        end
    end

    always_comb begin
        n_count = do_ins ? r_count + 1'b1 : r_count;
        cnt_ext = {{stis_pkg::CNT_OUT{1'b0}}, n_count};
        n_out.found       = (i_job.op == stis_pkg::OP_SEARCH) && hit;
        n_out.refused     = (i_job.op == stis_pkg::OP_INSERT) && full;
        n_out.entry_count = cnt_ext[stis_pkg::CNT_OUT-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_ins) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_cell[k] <= n_cell[k];
            end
        end
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* rtl/sorted_table_insert_search.sv */
// Top level of the sorted table block: front queue feeding the cell chain.
//
// Input channel (i_valid / o_stall / i_data): one word is a command and a
// signed 32-bit value. Command insert stores the value in ascending order,
// after any equal entries; command search looks for an equal entry.
// Output channel (o_valid / i_stall / o_data): exactly one result word per
// input word, in order: found (search), refused (insert on a full table)
// and the entry count after the step, masked to 5 bits.
// Path: an accepted word is registered in the front queue, then the cell
// chain loads the output register from it. Throughput: one word per cycle
// while i_stall is low; the rate is set by the cell chain, where all DEPTH
// cells compare and shift together.
// A 2-word queue sits between front and back, so o_stall rises only when
// the queue is full; the output register holds its word while i_stall is
// high and the back end refills it in the same cycle the word is taken.
// Reset (synchronous, active low) empties the queue, drops any pending
// result and sets the entry count to zero; the entries are not cleared.
module sorted_table_insert_search #(
    parameter int DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  stis_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output stis_pkg::t_out o_data
);

    // decoded job handed from front to back
    logic           job_valid;
    logic           job_pop;
    stis_pkg::t_job job;

    // front: accept and decode, buffer up to two jobs
    stis_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_job_valid (job_valid),
        .i_job_pop   (job_pop),
        .o_job       (job)
    );

    // back: sorted cell chain, counts entries, drives the result register
    stis_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_pop   (job_pop),
        .i_job       (job),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

endmodule

/* rtl/stis_checker.sv */
// Port-level checker for the sorted table block and its bind.
`include "assert_macros.svh"

module stis_checker #(
    parameter int DEPTH = 16
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input stis_pkg::t_in  i_data,
    input logic           o_valid,
    input logic           i_stall,
    input stis_pkg::t_out o_data
);

    logic in_take;
    assign in_take = i_valid && !o_stall && (i_data.command || !i_data.command);

    `STIS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `STIS_ASSERT_IMP(a_one_flag, i_clk, i_rst_n, o_valid, !(o_data.found && o_data.refused))
    `STIS_ASSERT_IMP(a_count_max, i_clk, i_rst_n, o_valid && (DEPTH < 32), o_data.entry_count <= 5'(DEPTH))
    `STIS_ASSERT_NXT(a_in_latency, i_clk, i_rst_n, $past(in_take && !o_valid), o_valid)
    `STIS_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n, !o_valid && !o_stall)

endmodule

bind sorted_table_insert_search stis_checker #(.DEPTH(DEPTH)) u_stis_checker (.*);

/* tb/stis_result_checker.sv */
// Result checker for the sorted table block: tracks the table and compares every output word.
`timescale 1ns / 1ps

module stis_result_checker #(
    parameter int DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  stis_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  stis_pkg::t_out i_out_data,
    output int             o_fail_count,
    output int             o_pending
);

    // Shadow of the table: only the lowest tbl_count places are meaningful.
    logic signed [stis_pkg::VAL_W-1:0] tbl_vals [DEPTH];
    int                                tbl_count;
    stis_pkg::t_out                    table_results [$];
    stis_pkg::t_out                    want;

    initial begin
        tbl_count    = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Applies one word to the shadow table and returns the result it causes.
    function automatic stis_pkg::t_out apply_table_word(input stis_pkg::t_in w);
        stis_pkg::t_out                    res;
        logic signed [stis_pkg::VAL_W-1:0] v;
        int                                pos;
        res = '0;
        v   = w.value;
        if (w.command == stis_pkg::OP_INSERT) begin
            if (tbl_count >= DEPTH) begin
                res.refused = 1'b1;
            end else begin
                pos = 0;
                while (pos < tbl_count && tbl_vals[pos] <= v) pos++;
                for (int k = tbl_count; k > pos; k--) tbl_vals[k] = tbl_vals[k-1];
                tbl_vals[pos] = v;
                tbl_count++;
            end
        end else begin
            for (int k = 0; k < tbl_count; k++) begin
                if (tbl_vals[k] == v) res.found = 1'b1;
            end
        end
        res.entry_count = tbl_count[stis_pkg::CNT_OUT-1:0];
        return res;
    endfunction

    // Sample at the falling edge: values are stable and belong to the next rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) table_results.push_back(apply_table_word(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (table_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result word with nothing expected: %p", $time, i_out_data);
                end else begin
                    want = table_results.pop_front();
                    if (i_out_data.found !== want.found || i_out_data.refused !== want.refused
                        || i_out_data.entry_count !== want.entry_count) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: mismatch found %b/%b refused %b/%b count %0d/%0d",
                                     $time, want.found, i_out_data.found, want.refused,
                                     i_out_data.refused, want.entry_count,
                                     i_out_data.entry_count);
                    end
                end
            end
        end
        o_pending = table_results.size();
    end

endmodule

/* tb/sorted_table_insert_search_tb.sv */
// Top of the sorted table testbench: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module sorted_table_insert_search_tb;

    localparam int TABLE_DEPTH     = 16;
    localparam int PHASE_WORDS     = 325;   // four phases, about 1300 random words
    localparam int PRESSURE_CYCLES = 64;    // long receiver hold-off
    localparam int WATCHDOG_LIMIT  = 1000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES    = 20;    // spare cycles waited after the last expected result

    logic           clk;
    logic           rst_n;
    logic           tx_valid;
    stis_pkg::t_in  tx_data;
    logic           dut_stall;
    logic           dut_valid;
    logic           rx_stall;
    stis_pkg::t_out dut_data;
    int             fail_count;
    int             pending;

    // Idle and stall chances, in percent, set per phase by the stimulus.
    int   tx_idle_pct;
    int   rx_stall_pct;
    bit   pressure_req;
    bit   pressure_done;

    // Values actually stored, used to aim searches at held entries.
    logic [stis_pkg::VAL_W-1:0] held_vals [$];

    sorted_table_insert_search #(
        .DEPTH (TABLE_DEPTH)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (tx_valid),
        .o_stall (dut_stall),
        .i_data  (tx_data),
        .o_valid (dut_valid),
        .i_stall (rx_stall),
        .o_data  (dut_data)
    );

    stis_result_checker #(
        .DEPTH (TABLE_DEPTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (tx_valid),
        .i_in_stall   (dut_stall),
        .i_in_data    (tx_data),
        .i_out_valid  (dut_valid),
        .i_out_stall  (rx_stall),
        .i_out_data   (dut_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one word, with random idle cycles ahead of it, and returns at the
    // rising edge that takes it. o_stall is read at the falling edge before.
    task automatic send_word(input stis_pkg::t_op op, input logic [stis_pkg::VAL_W-1:0] v);
        bit taken;
        while ($urandom_range(99) < tx_idle_pct) begin
            tx_valid <= 1'b0;
            @(posedge clk);
        end
        tx_valid <= 1'b1;
        tx_data  <= {op, v};
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = !dut_stall;
            @(posedge clk);
        end
        if (op == stis_pkg::OP_INSERT && held_vals.size() < TABLE_DEPTH) held_vals.push_back(v);
    endtask

    // Receiver: random stalls, plus one long hold-off while the sender keeps
    // offering words, so the front queue fills and o_stall has to rise.
    initial begin : rx_side
        int hold;
        rx_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (pressure_req && !pressure_done) begin
                rx_stall <= 1'b1;
                hold = 0;
                while (hold < PRESSURE_CYCLES) begin
                    @(posedge clk);
                    hold++;
                end
                pressure_done = 1'b1;
            end else begin
                rx_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    // Watchdog: ends the run if no word moves on either channel for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(negedge clk);
            if ((tx_valid && !dut_stall) || (dut_valid && !rx_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int                         tx_idle_by_phase [4];
        int                         rx_stall_by_phase [4];
        int                         pick;
        logic [stis_pkg::VAL_W-1:0] v;
        tx_idle_by_phase  = '{0, 53, 0, 20};
        rx_stall_by_phase = '{0, 0, 53, 20};
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        pressure_req  = 1'b0;
        pressure_done = 1'b0;
        rst_n    <= 1'b0;
        tx_valid <= 1'b0;
        tx_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty-table search, extremes, duplicates, neighbors
        // of held values, filling the table, then an insert into a full table.
        send_word(stis_pkg::OP_SEARCH, 32'h0000_0000);
        send_word(stis_pkg::OP_INSERT, 32'h0000_0000);
        send_word(stis_pkg::OP_SEARCH, 32'h0000_0000);
        send_word(stis_pkg::OP_INSERT, 32'h7FFF_FFFF);
        send_word(stis_pkg::OP_INSERT, 32'h8000_0000);
        send_word(stis_pkg::OP_SEARCH, 32'h8000_0000);
        send_word(stis_pkg::OP_SEARCH, 32'h7FFF_FFFF);
        send_word(stis_pkg::OP_INSERT, 32'hFFFF_FFFF);
        send_word(stis_pkg::OP_INSERT, 32'h0000_0001);
        send_word(stis_pkg::OP_INSERT, 32'h0000_0005);
        send_word(stis_pkg::OP_INSERT, 32'h0000_0005);
        send_word(stis_pkg::OP_SEARCH, 32'h0000_0005);
        send_word(stis_pkg::OP_SEARCH, 32'h0000_0004);
        send_word(stis_pkg::OP_SEARCH, 32'h7FFF_FFFE);
        send_word(stis_pkg::OP_INSERT, 32'h8000_0000);
        send_word(stis_pkg::OP_INSERT, 32'h7FFF_FFFF);
        send_word(stis_pkg::OP_INSERT, 32'h5555_5555);
        send_word(stis_pkg::OP_INSERT, 32'hAAAA_AAAA);
        send_word(stis_pkg::OP_INSERT, -32'sd100);
        send_word(stis_pkg::OP_INSERT, 32'd100);
        send_word(stis_pkg::OP_INSERT, 32'h1234_5678);
        send_word(stis_pkg::OP_INSERT, 32'd42);
        send_word(stis_pkg::OP_INSERT, -32'sd42);
        send_word(stis_pkg::OP_INSERT, 32'h0000_0000);
        send_word(stis_pkg::OP_SEARCH, -32'sd42);
        send_word(stis_pkg::OP_SEARCH, 32'd6);

        // Random part. The table is full from here on, so most words are
        // searches aimed at held values and their neighbors.
        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = tx_idle_by_phase[ph];
            rx_stall_pct = rx_stall_by_phase[ph];
            if (ph == 0) pressure_req = 1'b1;
            repeat (PHASE_WORDS) begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    send_word(stis_pkg::OP_SEARCH,
                              held_vals[$urandom_range(held_vals.size() - 1)]);
                end else if (pick < 55) begin
                    v = held_vals[$urandom_range(held_vals.size() - 1)];
                    send_word(stis_pkg::OP_SEARCH, $urandom_range(1) ? v + 1 : v - 1);
                end else if (pick < 75) begin
                    send_word(stis_pkg::OP_SEARCH, $urandom);
                end else if (pick < 85) begin
                    send_word(stis_pkg::OP_SEARCH, $urandom_range(20) - 10);
                end else if (pick < 95) begin
                    send_word(stis_pkg::OP_INSERT, $urandom);
                end else begin
                    send_word(stis_pkg::OP_INSERT,
                              $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
                end
            end
        end
        tx_valid <= 1'b0;

        // Drain: no more stalls, wait for every result, then a few spare cycles
        // to catch any stray word.
        rx_stall_pct = 0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/stis_pkg.sv
rtl/stis_front.sv
rtl/stis_back.sv
rtl/sorted_table_insert_search.sv
rtl/stis_checker.sv
tb/stis_result_checker.sv
tb/sorted_table_insert_search_tb.sv
